@@ design/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, constants and helpers of the bitmap run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

  localparam int WORD_BITS     = 64;
  localparam int MAP_WORDS_DEF = 64;
  localparam int LEN_W         = 7;
  localparam int IDX_W         = 12;
  localparam int TOT_W         = 13;
  localparam int STAT_W        = 2;

  localparam logic [TOT_W-1:0] TOTAL_BITS_RST = 13'd4096;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_BAD   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_REL_CHK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    scan_step;
    logic    alloc_wr;
    logic    rel_rd;
    logic    rel_wr;
    logic    set_res;
    status_t res_code;
    logic    hint_inc;
    logic    hint_low;
    logic    push;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic cmd_rel;
    logic len_bad;
    logic rel_bad;
    logic words_zero;
    logic scan_hit;
    logic scan_done;
    logic rel_match;
    logic out_free;
  } dp_stat_t;

  // Run of len ones from bit 0; 64 and above give a full word.
  function automatic logic [WORD_BITS-1:0] run_mask(input logic [LEN_W-1:0] len);
    logic [WORD_BITS-1:0] m;
    if (len >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << len) - 64'd1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ design/bra_datapath.sv @@
// ----------------------------------------------------------------------------
// bra_datapath
// Bitmap memory, request registers, word scan logic, hint and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_datapath #(
  parameter int MAP_WORDS = bra_pkg::MAP_WORDS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bra_pkg::ctrl_cmd_t        cmd,
  output bra_pkg::dp_stat_t              stat,
  input  wire logic                      cfg_wr_en,
  input  wire logic [bra_pkg::TOT_W-1:0] cfg_wr_data,
  input  wire logic                      in_cmd,
  input  wire logic [bra_pkg::LEN_W-1:0] in_len,
  input  wire logic [bra_pkg::IDX_W-1:0] in_rel,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output bra_pkg::status_t               out_status,
  output logic [bra_pkg::IDX_W-1:0]      out_first
);

  localparam int AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MAX_USED = (MAP_WORDS < 128) ? MAP_WORDS : 128;
  localparam int WCW      = $clog2(MAX_USED + 1);
  localparam int CAP_INT  = (MAP_WORDS * 64 < 8191) ? MAP_WORDS * 64 : 8191;
  localparam int IW       = bra_pkg::IDX_W;
  localparam int LW       = bra_pkg::LEN_W;
  localparam int TW       = bra_pkg::TOT_W;
  localparam int WB       = bra_pkg::WORD_BITS;
  localparam logic [TW-1:0] CAP = TW'(CAP_INT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
  localparam bit REL_ALL_WORDS = (MAP_WORDS >= 64);

  logic [WB-1:0] mem [MAP_WORDS];
  logic [WB-1:0] mem_q;

  logic [TW-1:0]  tot_bits;
  logic           cmd_r;
  logic [LW-1:0]  len_r;
  logic [IW-1:0]  rel_r;
  logic [TW-1:0]  lim_r;
  logic [WCW-1:0] words_r;
  logic [WB-1:0]  mask_r;
  logic [WB-1:0]  wr_mask;
  logic [WCW-1:0] hint;

  logic [AW-1:0]  clr_addr;
  logic [WCW-1:0] rd_word;
  logic [WCW-1:0] issued;
  logic           eval_valid;
  logic           eval_last;
  logic [WCW-1:0] eval_w;

  logic [WB-1:0]  hit_word;
  logic [5:0]     hit_s;
  logic [AW-1:0]  hit_addr;

  bra_pkg::status_t res_status;
  logic [IW-1:0]    res_first;

  logic [TW-1:0]   lim_c;
  logic [TW:0]     lim_sum;
  logic [WCW-1:0]  words_c;
  logic [WCW-1:0]  start_c;
  logic            issue;
  logic [AW-1:0]   rel_addr;
  logic [13:0]     wbase;
  logic [13:0]     diff;
  logic [6:0]      room;
  logic [WB-1:0]   fit;
  logic            any_fit;
  logic [5:0]      fit_s;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [WB-1:0]   mem_wd;
  logic            mem_re;
  logic [AW-1:0]   mem_ra;
  logic [AW+5:0]   hit_idx;

  // Words in use and start word, from the current register value.
  always_comb begin
    lim_c   = (tot_bits < CAP) ? tot_bits : CAP;
    lim_sum = {1'b0, lim_c} + (TW+1)'(63);
    words_c = WCW'(lim_sum >> 6);
    start_c = (hint < words_c) ? hint : '0;
  end

  assign issue    = cmd.scan_step && (issued != words_r);
  assign rel_addr = AW'(rel_r[11:6]);

  // Room left in the word under evaluation, capped at a full word.
  always_comb begin
    wbase = 14'(eval_w) << 6;
    diff  = {1'b0, lim_r} - wbase;
    room  = (diff >= 14'd64) ? 7'd64 : diff[6:0];
  end

  // Lowest free run that fits the word.
  always_comb begin
    for (int s = 0; s < WB; s++) begin
      fit[s] = ((mem_q & (mask_r << s)) == '0) && ((7'(s) + len_r) <= room);
    end
    any_fit = |fit;
    fit_s   = '0;
    for (int s = WB - 1; s >= 0; s--) begin
      if (fit[s]) begin
        fit_s = 6'(s);
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    priority if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.alloc_wr) begin
      mem_we = 1'b1;
      mem_wa = hit_addr;
      mem_wd = hit_word | (mask_r << hit_s);
    end else if (cmd.rel_wr) begin
      mem_we = 1'b1;
      mem_wa = rel_addr;
      mem_wd = mem_q & ~wr_mask;
    end
    mem_re = issue || cmd.rel_rd;
    mem_ra = cmd.rel_rd ? rel_addr : AW'(rd_word);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  assign hit_idx = {hit_addr, hit_s};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tot_bits   <= bra_pkg::TOTAL_BITS_RST;
      hint       <= '0;
      clr_addr   <= '0;
      eval_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tot_bits <= cfg_wr_data;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.load) begin
        eval_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        eval_valid <= issue;
      end
      if (cmd.hint_inc && (hint < words_r)) begin
        hint <= hint + WCW'(1);
      end else if (cmd.hint_low && (32'(hint) > 32'(rel_r[11:6]))) begin
        hint <= WCW'(rel_r[11:6]);
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      len_r   <= in_len;
      rel_r   <= in_rel;
      lim_r   <= lim_c;
      words_r <= words_c;
      mask_r  <= bra_pkg::run_mask(in_len);
      rd_word <= start_c;
      issued  <= '0;
    end else if (issue) begin
      rd_word   <= (rd_word == words_r - WCW'(1)) ? '0 : rd_word + WCW'(1);
      issued    <= issued + WCW'(1);
      eval_w    <= rd_word;
      eval_last <= (issued + WCW'(1)) == words_r;
    end
    if (cmd.rel_rd) begin
      wr_mask <= mask_r << rel_r[5:0];
    end
    if (cmd.scan_step && eval_valid && any_fit) begin
      hit_word <= mem_q;
      hit_s    <= fit_s;
      hit_addr <= AW'(eval_w);
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      if (cmd.res_code == bra_pkg::STAT_OK) begin
        res_first <= cmd_r ? rel_r : IW'(hit_idx);
      end else begin
        res_first <= '0;
      end
    end
    if (cmd.push) begin
      out_status <= res_status;
      out_first  <= res_first;
    end
  end

  always_comb begin
    stat.clr_last   = (clr_addr == LAST_ADDR);
    stat.cmd_rel    = cmd_r;
    stat.len_bad    = (len_r == '0) || (len_r > 7'd64);
    stat.rel_bad    = stat.len_bad ||
                      (({2'b00, rel_r[5:0]} + {1'b0, len_r}) > 8'd64) ||
                      (!REL_ALL_WORDS && (rel_r[11:6] >= 6'(MAP_WORDS)));
    stat.words_zero = (words_r == '0);
    stat.scan_hit   = eval_valid && any_fit;
    stat.scan_done  = eval_valid && eval_last && !any_fit;
    stat.rel_match  = (mem_q & wr_mask) == wr_mask;
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

@@ design/bra_ctrl.sv @@
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer of the allocator: clearing pass, decode, scan or release check, write back, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire bra_pkg::dp_stat_t stat,
  output bra_pkg::ctrl_cmd_t     cmd
);

  bra_pkg::state_t state;
  bra_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bra_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bra_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = bra_pkg::ST_IDLE;
      end
      bra_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = bra_pkg::ST_DECODE;
      end
      bra_pkg::ST_DECODE: begin
        priority if (!stat.cmd_rel && (stat.len_bad || stat.words_zero)) begin
          state_next = bra_pkg::ST_DONE;
        end else if (!stat.cmd_rel) begin
          state_next = bra_pkg::ST_SCAN;
        end else if (stat.rel_bad) begin
          state_next = bra_pkg::ST_DONE;
        end else begin
          state_next = bra_pkg::ST_REL_CHK;
        end
      end
      bra_pkg::ST_SCAN: begin
        priority if (stat.scan_hit) begin
          state_next = bra_pkg::ST_ALLOC_WR;
        end else if (stat.scan_done) begin
          state_next = bra_pkg::ST_DONE;
        end
      end
      bra_pkg::ST_ALLOC_WR: state_next = bra_pkg::ST_DONE;
      bra_pkg::ST_REL_CHK:  state_next = bra_pkg::ST_DONE;
      bra_pkg::ST_DONE: begin
        if (stat.out_free) state_next = bra_pkg::ST_IDLE;
      end
      default: state_next = bra_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      bra_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      bra_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      bra_pkg::ST_DECODE: begin
        priority if (!stat.cmd_rel && stat.len_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = bra_pkg::STAT_BAD;
        end else if (!stat.cmd_rel && stat.words_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = bra_pkg::STAT_NOFIT;
          cmd.hint_inc = 1'b1;
        end else if (!stat.cmd_rel) begin
          cmd.scan_step = 1'b1;
        end else if (stat.rel_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = bra_pkg::STAT_BAD;
        end else begin
          cmd.rel_rd = 1'b1;
        end
      end
      bra_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = bra_pkg::STAT_NOFIT;
          cmd.hint_inc = 1'b1;
        end
      end
      bra_pkg::ST_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = bra_pkg::STAT_OK;
      end
      bra_pkg::ST_REL_CHK: begin
        cmd.set_res = 1'b1;
        if (stat.rel_match) begin
          cmd.rel_wr   = 1'b1;
          cmd.hint_low = 1'b1;
          cmd.res_code = bra_pkg::STAT_OK;
        end else begin
          cmd.res_code = bra_pkg::STAT_BAD;
        end
      end
      bra_pkg::ST_DONE: begin
        cmd.push = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/bitmap_run_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// Next-fit run allocator over a bitmap of 64-bit words.
// Flow: an allocate goes from accept through DECODE and SCAN (one word a cycle
//   through the bitmap read port) to ALLOC_WR and DONE, or to DONE when no word
//   fits; a release via DECODE, REL_CHK and DONE; a bad request from DECODE to DONE.
// Requests: one at a time; the next is taken in the cycle after the result is
//   loaded into the output register.
// Reset: rst (synchronous) clears the hint, sets total_bits to 4096 and starts
//   a clearing pass that zeroes every bitmap word, with s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_run_allocator #(
  parameter int MAP_WORDS = bra_pkg::MAP_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: total_bits.
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  // Request channel.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [6:0] run_length, [18:7] release_index
  input  wire logic        s_tuser,   // [0] cmd (0 allocate, 1 release)
  // Result channel.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [11:0] first_index
  output logic [1:0]       m_tuser    // [1:0] status
);

  bra_pkg::ctrl_cmd_t cmd;
  bra_pkg::dp_stat_t  stat;
  bra_pkg::status_t   out_status;
  logic [11:0]        out_first;

  // Sequencer: walks each request through decode, scan or check, and result.
  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: bitmap memory, scan pipeline, hint and result registers.
  bra_datapath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (s_tuser),
    .in_len      (s_tdata[6:0]),
    .in_rel      (s_tdata[18:7]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .out_status  (out_status),
    .out_first   (out_first)
  );

  // Pad first_index to a whole number of bytes.
  assign m_tdata = {4'b0000, out_first};
  assign m_tuser = out_status;

endmodule

`default_nettype wire
